// ----- rtl/spf_pkg.sv -----
`default_nettype none

package spf_pkg;

  // Width of an input number and of a factor
  localparam int unsigned NUM_W = 16;

  // Most results one input can produce
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned CNT_W = $clog2(RESULT_LIMIT);

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [CNT_W-1:0] cnt_t;

endpackage

`default_nettype wire

// ----- rtl/sieve_prime_factorizer_unit.sv -----
`default_nettype none

// Channel  Dir  tdata                 tuser               tlast
// in_      in   [15:0] number         -                   -
// out_     out  [15:0] factor         [0] input_is_prime  last_factor
//
// After reset the smallest-factor table is built in the table memory: each
// entry is seeded with its own index, one write per cycle, then each trial
// divisor up to sqrt(MAX_NUMBER) takes a setup step and writes its multiples,
// one per cycle. in_tready stays low until done. Each factor then takes a
// table read, a pass of the bit-serial divider and a hand-off of the result
// to the output register. Inputs 0, 1 and those above MAX_NUMBER skip the
// table and the divider and give factor 1 alone. A new number is taken only
// once the last result of the one before has gone to the output register.
// A full output register stalls the sequencer in its emit step only.
module sieve_prime_factorizer_unit #(
  parameter int unsigned MAX_NUMBER = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] number
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] factor
  output logic             out_tuser,  // [0] input_is_prime
  output logic             out_tlast   // last_factor
);

  function automatic int unsigned isqrt(input int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r = r + 1;
    return r;
  endfunction

  localparam int unsigned LIMIT = (MAX_NUMBER < 65535) ? MAX_NUMBER : 65535;
  localparam int unsigned DEPTH = LIMIT + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned ROOT  = isqrt(LIMIT);
  localparam int unsigned RW    = $clog2(ROOT + 1);
  localparam int unsigned SW    = $clog2(spf_pkg::NUM_W);

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_SIEVE = 7'b0000100,
    ST_IDLE  = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [RW-1:0]     i_r, i_nxt;
  logic [AW-1:0]     j_r, j_nxt;
  logic [AW:0]       j_sum;
  spf_pkg::num_t     rem_r, rem_nxt;
  spf_pkg::num_t     div_p_r, div_p_nxt;
  spf_pkg::num_t     div_quo_r, div_quo_nxt;
  spf_pkg::num_t     div_rem_r, div_rem_nxt;
  logic [spf_pkg::NUM_W:0] trial;
  logic [SW-1:0]     step_r, step_nxt;
  spf_pkg::cnt_t     cnt_r, cnt_nxt;
  logic              prime_r, prime_nxt;
  logic              last_res;

  logic              out_valid_r, out_valid_nxt;
  spf_pkg::num_t     out_factor_r, out_factor_nxt;
  logic              out_prime_r, out_prime_nxt;
  logic              out_last_r, out_last_nxt;
  logic              slot_free;

  spf_pkg::num_t     mem [DEPTH];
  spf_pkg::num_t     rd_data_r;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  spf_pkg::num_t     mem_wdata;

  logic              in_xfer;
  logic              special;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign special    = (in_tdata < spf_pkg::num_t'(2)) ||
                      (in_tdata > spf_pkg::num_t'(LIMIT));
  assign slot_free  = !out_valid_r || out_tready;
  assign j_sum      = {1'b0, j_r} + (AW+1)'(i_r);
  assign trial      = {div_rem_r, div_quo_r[spf_pkg::NUM_W-1]};
  assign last_res   = (div_quo_r <= spf_pkg::num_t'(1)) ||
                      (cnt_r == spf_pkg::cnt_t'(spf_pkg::RESULT_LIMIT - 1));

  // Table memory: single port, registered read
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = spf_pkg::num_t'(k_r);
    mem_addr  = '0;
    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = k_r;
        mem_wdata = spf_pkg::num_t'(k_r);
      end
      ST_SIEVE: begin
        mem_we    = 1'b1;
        mem_addr  = j_r;
        mem_wdata = spf_pkg::num_t'(i_r);
      end
      ST_IDLE:  mem_addr = in_tdata[AW-1:0];
      ST_EMIT:  mem_addr = div_quo_r[AW-1:0];
      default:  mem_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    rem_nxt        = rem_r;
    div_p_nxt      = div_p_r;
    div_quo_nxt    = div_quo_r;
    div_rem_nxt    = div_rem_r;
    step_nxt       = step_r;
    cnt_nxt        = cnt_r;
    prime_nxt      = prime_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_factor_nxt = out_factor_r;
    out_prime_nxt  = out_prime_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_INIT: begin
        // seed every entry with its own index
        k_nxt = k_r + AW'(1);
        if (k_r == AW'(LIMIT)) begin
          i_nxt     = RW'(ROOT);
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        j_nxt     = AW'({{RW{1'b0}}, i_r} * {{RW{1'b0}}, i_r});
        state_nxt = ST_SIEVE;
      end
      ST_SIEVE: begin
        // divisors run downward so the smallest one writes last
        j_nxt = j_sum[AW-1:0];
        if (j_sum > (AW+1)'(LIMIT)) begin
          if (i_r == RW'(2)) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r - RW'(1);
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          rem_nxt = in_tdata;
          cnt_nxt = '0;
          if (special) begin
            // factor 1, quotient 0 marks the single last result
            div_p_nxt   = spf_pkg::num_t'(1);
            div_quo_nxt = '0;
            prime_nxt   = 1'b0;
            state_nxt   = ST_EMIT;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (cnt_r == '0) begin
          prime_nxt = (rd_data_r == rem_r);
        end
        div_p_nxt   = rd_data_r;
        div_quo_nxt = rem_r;
        div_rem_nxt = '0;
        step_nxt    = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        if (trial >= {1'b0, div_p_r}) begin
          div_rem_nxt = spf_pkg::num_t'(trial - {1'b0, div_p_r});
          div_quo_nxt = {div_quo_r[spf_pkg::NUM_W-2:0], 1'b1};
        end else begin
          div_rem_nxt = trial[spf_pkg::NUM_W-1:0];
          div_quo_nxt = {div_quo_r[spf_pkg::NUM_W-2:0], 1'b0};
        end
        step_nxt = step_r + SW'(1);
        if (step_r == SW'(spf_pkg::NUM_W - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register can take the result
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = div_p_r;
          out_prime_nxt  = prime_r;
          out_last_nxt   = last_res;
          if (last_res) begin
            state_nxt = ST_IDLE;
          end else begin
            rem_nxt   = div_quo_r;
            cnt_nxt   = cnt_r + spf_pkg::cnt_t'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    rem_r        <= rem_nxt;
    div_p_r      <= div_p_nxt;
    div_quo_r    <= div_quo_nxt;
    div_rem_r    <= div_rem_nxt;
    step_r       <= step_nxt;
    cnt_r        <= cnt_nxt;
    prime_r      <= prime_nxt;
    out_factor_r <= out_factor_nxt;
    out_prime_r  <= out_prime_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_factor_r;
  assign out_tuser  = out_prime_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/spf_checker.sv -----
`default_nettype none

module spf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [15:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  spf_pkg::num_t prev_factor_r;
  logic          mid_item_r;
  logic          out_xfer;

  assign out_xfer = out_tvalid && out_tready;

  // track the previous factor of the item in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_item_r <= 1'b0;
    end else if (out_xfer) begin
      mid_item_r <= !out_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      prev_factor_r <= out_tdata;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_factor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 16'd0)
    else $error("zero factor");

  a_one_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == 16'd1 |-> out_tlast && !out_tuser)
    else $error("factor 1 not a lone non-prime result");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mid_item_r |-> out_tdata >= prev_factor_r)
    else $error("factors out of order");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata != 16'hFFFF |=> !in_tready)
    else $error("second item taken while one is in work");

endmodule

bind sieve_prime_factorizer_unit spf_checker u_spf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ----- bench/sieve_prime_factorizer_unit_test.sv -----
`default_nettype none

module sieve_prime_factorizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_NUMBER   = 65535;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned DRAIN_CYCLES = 1 + 18 * spf_pkg::RESULT_LIMIT + 20;
  // room for the table build plus every item at its slowest, several times over
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;

  localparam int unsigned SMALL_PRIMES [6] = '{2, 3, 5, 7, 11, 13};
  localparam int unsigned KNOWN_PRIMES [8] =
    '{65521, 65519, 32749, 8191, 4093, 257, 251, 127};

  typedef struct packed {
    spf_pkg::num_t factor;
    logic          prime;
    logic          last;
  } factor_result_t;

  // typed rows carry a single known result; the rest go through the predictor
  typedef struct packed {
    spf_pkg::num_t number;
    logic          typed;
    spf_pkg::num_t factor;
    logic          prime;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [20] = '{
    '{16'd0,     1'b1, 16'd1,     1'b0},
    '{16'd1,     1'b1, 16'd1,     1'b0},
    '{16'd2,     1'b1, 16'd2,     1'b1},
    '{16'd3,     1'b1, 16'd3,     1'b1},
    '{16'd65521, 1'b1, 16'd65521, 1'b1},
    '{16'd4,     1'b0, 16'd0,     1'b0},
    '{16'd6,     1'b0, 16'd0,     1'b0},
    '{16'd9,     1'b0, 16'd0,     1'b0},
    '{16'd30,    1'b0, 16'd0,     1'b0},
    '{16'd49,    1'b0, 16'd0,     1'b0},
    '{16'd255,   1'b0, 16'd0,     1'b0},
    '{16'd30030, 1'b0, 16'd0,     1'b0},
    '{16'd32768, 1'b0, 16'd0,     1'b0},
    '{16'd62208, 1'b0, 16'd0,     1'b0},
    '{16'd63001, 1'b0, 16'd0,     1'b0},
    '{16'd65280, 1'b0, 16'd0,     1'b0},
    '{16'd65534, 1'b0, 16'd0,     1'b0},
    '{16'd65535, 1'b0, 16'd0,     1'b0},
    '{16'h5555,  1'b0, 16'd0,     1'b0},
    '{16'hAAAA,  1'b0, 16'd0,     1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [15:0] number
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [15:0] factor
  logic        out_tuser;   // [0] input_is_prime
  logic        out_tlast;   // last_factor

  factor_result_t expected_factors [$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    send_idle_pct;
  int unsigned    stall_pct;

  sieve_prime_factorizer_unit #(
    .MAX_NUMBER(MAX_NUMBER)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Append one expected result at the tail of the queue.
  function automatic void add_expected(input factor_result_t res);
    expected_factors.insert(expected_factors.size(), res);
  endfunction

  // Trial division gives the prime factors in ascending order; numbers below 2 or above MAX_NUMBER give a lone 1.
  function automatic void push_prime_factors(input spf_pkg::num_t number);
    int unsigned   rest;
    int unsigned   divisor;
    spf_pkg::num_t found [$];
    logic          n_prime;
    rest = number;
    divisor = 2;
    if (number < 2 || number > MAX_NUMBER) begin
      add_expected('{factor: 16'd1, prime: 1'b0, last: 1'b1});
      return;
    end
    while (rest > 1 && found.size() < spf_pkg::RESULT_LIMIT) begin
      while (rest % divisor != 0 && divisor * divisor <= rest) divisor++;
      if (rest % divisor != 0) divisor = rest;
      found.insert(found.size(), spf_pkg::num_t'(divisor));
      rest = rest / divisor;
    end
    n_prime = (found.size() == 1);
    foreach (found[i])
      add_expected('{factor: found[i], prime: n_prime,
                     last: (i == found.size() - 1)});
  endfunction

  function automatic spf_pkg::num_t random_number();
    int unsigned value;
    int unsigned pick;
    value = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: value = $urandom_range(0, 65535);
      4: value = $urandom_range(0, 31);
      5: value = $urandom_range(1, 255) << $urandom_range(0, 8);
      6: begin
        // smooth numbers give long runs of factors
        for (int k = 0; k < 16; k++) begin
          pick = SMALL_PRIMES[$urandom_range(0, 5)];
          if (value * pick > 65535) break;
          value = value * pick;
        end
      end
      7: value = $urandom_range(65000, 65535);
      8: value = KNOWN_PRIMES[$urandom_range(0, 7)];
      default: value = $urandom_range(1, 3) << $urandom_range(10, 14);
    endcase
    return spf_pkg::num_t'(value);
  endfunction

  // Call at a falling edge; returns at the falling edge after the transfer.
  task automatic send_number(input directed_row_t row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= row.number;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (row.typed)
      add_expected('{factor: row.factor, prime: row.prime, last: 1'b1});
    else
      push_prime_factors(row.number);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    factor_result_t seen;
    factor_result_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      seen = '{factor: out_tdata, prime: out_tuser, last: out_tlast};
      if (expected_factors.size() == 0) begin
        $display("%0t: no result expected, got factor %0d prime %b last %b",
                 $time, seen.factor, seen.prime, seen.last);
        mismatch_count++;
      end else begin
        want = expected_factors.pop_front();
        if (seen !== want) begin
          $display("%0t: expected factor %0d prime %b last %b, got factor %0d prime %b last %b",
                   $time, want.factor, want.prime, want.last,
                   seen.factor, seen.prime, seen.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) send_number(DIRECTED_ROWS[i]);

    // no idling, sender idle, receiver stalling, then both
    for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
      send_idle_pct = (phase_idx == 1) ? 64 : (phase_idx == 3) ? 28 : 0;
      stall_pct     = (phase_idx == 2) ? 64 : (phase_idx == 3) ? 28 : 0;
      repeat (RANDOM_ITEMS / 4)
        send_number('{number: random_number(), typed: 1'b0, factor: '0, prime: 1'b0});
    end
    in_tvalid <= 1'b0;

    while (expected_factors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
